// ===== design/sha_pkg.sv =====
// shared types, constants and round functions for the sha-256 stream hasher
package sha_pkg;

  localparam logic [1:0] REQ_DATA    = 2'd0;
  localparam logic [1:0] REQ_FINISH  = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR_OUT,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // what the controller asks of the datapath
  typedef struct packed {
    logic       load_init;
    logic       write_byte;
    logic       write_pad;
    logic       start_block;
    logic       round;
    logic       update;
    logic       clear_len;
    logic [1:0] round_hi;
  } dp_cmd_t;

  // what the datapath reports back
  typedef struct packed {
    logic       block_full;
    logic       pad_last;
    logic       pad_needs_second;
  } dp_stat_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== design/sha_datapath.sv =====
// block buffer, message schedule, round registers and hash state
module sha_datapath (
  input  logic              clk,
  input  logic              rst,
  input  sha_pkg::dp_cmd_t  cmd,
  input  logic [7:0]        data_byte,
  input  logic [2:0]        word_sel,
  output sha_pkg::dp_stat_t stat,
  output logic [31:0]       digest_word
);
  import sha_pkg::*;

  logic [5:0]  byte_position;
  logic [63:0] bit_length;
  logic [31:0] hash_words [8];
  // holds the block as it fills, then slides as the message schedule
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [5:0]  round_cnt;
  logic [7:0]  fill_byte;
  logic [7:0]  wr_byte;
  logic [31:0] w_new, t1, t2, w_cur;
  logic [31:0] s0, s1;

  assign stat.block_full       = (byte_position == 6'd63);
  assign stat.pad_last         = (byte_position == 6'd63);
  assign stat.pad_needs_second = (byte_position > 6'd55);
  assign digest_word = hash_words[word_sel];

  // padding byte at the current position: zeros, then the length in bytes 56 to 63
  always_comb begin
    if (byte_position >= 6'd56 && !cmd.round_hi[0])
      fill_byte = bit_length[{~byte_position[2:0], 3'b000} +: 8];
    else
      fill_byte = 8'h00;
  end

  // round_hi[1] marks the 0x80 byte, round_hi[0] forces zero fill
  always_comb begin
    if (cmd.write_pad)
      wr_byte = cmd.round_hi[1] ? 8'h80 : fill_byte;
    else
      wr_byte = data_byte;
  end

  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
    w_cur = w[0];
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[round_cnt] + w_cur;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      bit_length    <= '0;
      round_cnt     <= '0;
      for (int i = 0; i < 8; i++) hash_words[i] <= INIT_HASH[i];
    end else begin
      if (cmd.load_init) begin
        byte_position <= '0;
        bit_length    <= '0;
        for (int i = 0; i < 8; i++) hash_words[i] <= INIT_HASH[i];
      end
      if (cmd.write_byte) begin
        byte_position <= byte_position + 6'd1;
        bit_length    <= bit_length + 64'd8;
      end
      if (cmd.write_pad) byte_position <= byte_position + 6'd1;
      // big-endian byte lanes within each schedule word
      if (cmd.write_byte || cmd.write_pad)
        w[byte_position[5:2]][{~byte_position[1:0], 3'b000} +: 8] <= wr_byte;
      if (cmd.clear_len) bit_length <= '0;
      if (cmd.start_block) begin
        round_cnt <= '0;
        {a, b, c, d} <= {hash_words[0], hash_words[1], hash_words[2], hash_words[3]};
        {e, f, g, h} <= {hash_words[4], hash_words[5], hash_words[6], hash_words[7]};
      end
      if (cmd.round) begin
        round_cnt <= round_cnt + 6'd1;
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= w_new;
        h <= g; g <= f; f <= e; e <= d + t1;
        d <= c; c <= b; b <= a; a <= t1 + t2;
      end
      if (cmd.update) begin
        hash_words[0] <= hash_words[0] + a; hash_words[1] <= hash_words[1] + b;
        hash_words[2] <= hash_words[2] + c; hash_words[3] <= hash_words[3] + d;
        hash_words[4] <= hash_words[4] + e; hash_words[5] <= hash_words[5] + f;
        hash_words[6] <= hash_words[6] + g; hash_words[7] <= hash_words[7] + h;
      end
    end
  end
endmodule

// ===== design/sha_control.sv =====
// controller state machine for the sha-256 stream hasher
module sha_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_tvalid,
  input  logic [1:0]        req_type,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic              out_err,
  output logic [2:0]        word_sel,
  input  sha_pkg::dp_stat_t stat,
  output sha_pkg::dp_cmd_t  cmd
);
  import sha_pkg::*;

  state_t state, state_next;
  logic   done_flag, error_flag;
  logic   second_block, marker_done, final_block;
  logic [5:0] rcnt;
  logic   acc;

  assign acc = in_tvalid && in_tready;
  assign in_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (acc) begin
        unique case (req_type)
          REQ_DATA: begin
            if (done_flag || error_flag) state_next = ST_ERR_OUT;
            else if (stat.block_full) state_next = ST_ROUND;
          end
          REQ_FINISH: begin
            if (error_flag) state_next = ST_ERR_OUT;
            else if (done_flag) state_next = ST_EMIT;
            else state_next = ST_PAD;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_ERR_OUT: if (out_tready) state_next = ST_IDLE;
      ST_PAD: if (stat.pad_last) state_next = ST_ROUND;
      ST_ROUND: if (rcnt == 6'd63) state_next = ST_UPDATE;
      ST_UPDATE: state_next = final_block ? ST_EMIT
                            : (second_block ? ST_PAD : ST_IDLE);
      ST_EMIT: if (out_tready && word_sel == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    out_tvalid = 1'b0;
    out_err = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.load_init   = acc && req_type == REQ_RESTART;
        cmd.write_byte  = acc && req_type == REQ_DATA && !done_flag && !error_flag;
        cmd.start_block = cmd.write_byte && stat.block_full;
      end
      ST_ERR_OUT: begin
        out_tvalid = 1'b1;
        out_err    = 1'b1;
      end
      ST_PAD: begin
        cmd.write_pad   = 1'b1;
        cmd.round_hi[1] = !marker_done;
        cmd.round_hi[0] = second_block;
        cmd.start_block = stat.pad_last;
      end
      ST_ROUND: cmd.round = 1'b1;
      ST_UPDATE: begin
        cmd.update    = 1'b1;
        cmd.clear_len = final_block;
      end
      ST_EMIT: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done_flag <= 1'b0; error_flag <= 1'b0;
      second_block <= 1'b0; marker_done <= 1'b0; final_block <= 1'b0;
      rcnt <= '0; word_sel <= '0;
    end else begin
      state <= state_next;
      if (cmd.start_block) rcnt <= '0;
      else if (cmd.round) rcnt <= rcnt + 6'd1;
      if (state == ST_IDLE && acc) begin
        word_sel <= '0;
        if (req_type == REQ_RESTART) begin
          done_flag <= 1'b0; error_flag <= 1'b0;
        end
        if (req_type == REQ_DATA && done_flag) error_flag <= 1'b1;
        if (req_type == REQ_FINISH) begin
          marker_done <= 1'b0; second_block <= 1'b0; final_block <= 1'b0;
        end
      end
      if (state == ST_PAD) begin
        marker_done <= 1'b1;
        // a marker too late for the length: this block is zero padded only
        if (!marker_done) begin
          second_block <= stat.pad_needs_second;
          final_block  <= !stat.pad_needs_second;
        end else if (stat.pad_last && second_block) begin
          final_block <= 1'b0;
        end
      end
      if (state == ST_UPDATE) begin
        if (second_block && !final_block) begin
          second_block <= 1'b0;
          final_block  <= 1'b1;
        end
        // later data blocks must not be taken for a padded one
        if (final_block) begin
          done_flag   <= 1'b1;
          final_block <= 1'b0;
        end
      end
      if (state == ST_EMIT && out_tready) word_sel <= word_sel + 3'd1;
    end
  end
endmodule

// ===== design/sha256_stream_hasher.sv =====
// a data item writes one byte; the item that fills a 64-byte block also starts its rounds
// a finish item pads one or two blocks, runs each block through the single round
// unit, then shows 8 result items
// an error result is a single item; a repeated finish only emits the digest
// rst is synchronous: it loads the initial hash and clears length and flags
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zeros
  output logic        m_tuser,   // status[0]
  output logic        m_tlast
);
  import sha_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [2:0] word_sel;
  logic [31:0] dword;
  logic       err;

  sha_control u_ctl (
    .clk, .rst, .in_tvalid(s_tvalid), .req_type(s_tuser), .in_tready(s_tready),
    .out_tready(m_tready), .out_tvalid(m_tvalid), .out_err(err), .word_sel,
    .stat, .cmd);

  sha_datapath u_dp (
    .clk, .rst, .cmd, .data_byte(s_tdata), .word_sel, .stat,
    .digest_word(dword));

  assign m_tdata = err ? 40'd0 : {5'd0, word_sel, dword};
  assign m_tuser = err;
  assign m_tlast = err || word_sel == 3'd7;
endmodule

// ===== design/sha_checker.sv =====
// port checker for the sha-256 stream hasher
module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 40'd0 && m_tlast)
    else $error("error item carries data");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast == (m_tdata[34:32] == 3'd7))
    else $error("last flag mismatch");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result dropped");
endmodule

bind sha256_stream_hasher sha_checker u_chk (
  .clk, .rst, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast);

// ===== dv/tb_sha256_stream_hasher.sv =====
// self-checking testbench for the sha-256 byte-stream hasher
module tb_sha256_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        status;
    logic        last;
  } digest_out_t;

  typedef struct {
    logic [1:0]  req;
    logic [7:0]  data;
    logic        has_exp;
    digest_out_t exp;
  } stim_row_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tready;
  logic        m_tvalid;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  sha256_stream_hasher u_top (.*);

  // predictor state
  logic [31:0] hash_st [8];
  logic [7:0]  blk_buf [64];
  int unsigned blk_pos;
  logic [63:0] msg_bits;
  logic        msg_done;
  logic        msg_err;

  digest_out_t digest_q [$];
  logic        has_override_q [$];
  digest_out_t override_q [$];
  int          fail_count;
  int          items_sent;
  int          words_seen;
  int          idle_cycles;
  bit          stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void run_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    {a, b, c, d, e, f, g, h} = {hash_st[0], hash_st[1], hash_st[2], hash_st[3],
                                hash_st[4], hash_st[5], hash_st[6], hash_st[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
    blk_pos = 0;
  endfunction

  function automatic void restart_msg();
    foreach (hash_st[i]) hash_st[i] = INIT_HASH[i];
    blk_pos = 0;
    msg_bits = '0;
    msg_done = 1'b0;
    msg_err = 1'b0;
  endfunction

  function automatic void push_error();
    digest_q.push_back('{word: '0, idx: '0, status: 1'b1, last: 1'b1});
  endfunction

  function automatic void hash_item(logic [1:0] req, logic [7:0] data);
    int unsigned p;
    case (req)
      REQ_DATA: begin
        if (msg_done) begin
          msg_err = 1'b1;
          push_error();
        end else if (msg_err) begin
          push_error();
        end else begin
          blk_buf[blk_pos & 63] = data;
          blk_pos = (blk_pos + 1) & 127;
          msg_bits += 64'd8;
          if (blk_pos >= 64) run_compress();
        end
      end
      REQ_FINISH: begin
        if (msg_err) begin
          push_error();
        end else begin
          if (!msg_done) begin
            p = blk_pos & 63;
            blk_buf[p] = 8'h80;
            p++;
            if (p > 56) begin
              while (p < 64) begin blk_buf[p] = 8'h00; p++; end
              run_compress();
              p = 0;
            end
            while (p < 56) begin blk_buf[p] = 8'h00; p++; end
            for (int i = 0; i < 8; i++) blk_buf[56+i] = msg_bits[63-8*i -: 8];
            run_compress();
            foreach (blk_buf[i]) blk_buf[i] = 8'h00;
            msg_bits = '0;
            msg_done = 1'b1;
          end
          for (int i = 0; i < 8; i++)
            digest_q.push_back('{word: hash_st[i], idx: 3'(i), status: 1'b0,
                                 last: (i == 7)});
        end
      end
      REQ_RESTART: restart_msg();
      default: ;
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(logic [1:0] req, logic [7:0] data, logic has_exp,
                           digest_out_t exp);
    int n_before;
    int g;
    g = gap_len();
    // valid drops only for a real gap, so back-to-back items keep it high
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tuser <= req;
    n_before = digest_q.size();
    hash_item(req, data);
    // typed-in value applies to the first word the item yields
    if (has_exp && digest_q.size() > n_before) override_q.push_back(exp);
    for (int i = n_before; i < digest_q.size(); i++)
      has_override_q.push_back(has_exp && i == n_before);
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // output side: random stall, then compare
  always @(posedge clk) begin
    digest_out_t got, want, typed;
    logic use_typed;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{word: m_tdata[31:0], idx: m_tdata[34:32], status: m_tuser,
                last: m_tlast};
        words_seen++;
        if (digest_q.size() == 0) begin
          $error("unexpected result item: word %h", got.word);
          fail_count++;
        end else begin
          want = digest_q.pop_front();
          use_typed = has_override_q.pop_front();
          if (use_typed) begin
            typed = override_q.pop_front();
            if (typed !== want) begin
              $error("predictor disagrees with table: exp %h got %h", typed, want);
              fail_count++;
            end
          end
          if (got.word !== want.word) begin
            $error("digest_word exp %h got %h", want.word, got.word); fail_count++;
          end
          if (got.idx !== want.idx) begin
            $error("word_index exp %0d got %0d", want.idx, got.idx); fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last_word exp %0d got %0d", want.last, got.last); fail_count++;
          end
        end
      end
      if ($urandom_range(0, 9) < 7) m_tready <= 1'b1;
      else if ($urandom_range(0, 19) == 0) m_tready <= 1'b0;
      else m_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (!stim_done || digest_q.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  stim_row_t dir_rows [$];

  function automatic void add_row(logic [1:0] req, logic [7:0] data,
                                  logic has_exp = 1'b0, digest_out_t exp = '0);
    dir_rows.push_back('{req: req, data: data, has_exp: has_exp, exp: exp});
  endfunction

  task automatic send_message(int len, bit noisy);
    int k;
    send_item(REQ_RESTART, 8'($urandom), 1'b0, '0);
    for (int i = 0; i < len; i++) begin
      k = $urandom_range(0, 99);
      if (noisy && k < 3) send_item(REQ_UNUSED, 8'($urandom), 1'b0, '0);
      send_item(REQ_DATA, 8'($urandom), 1'b0, '0);
    end
    send_item(REQ_FINISH, 8'($urandom), 1'b0, '0);
    k = $urandom_range(0, 9);
    if (k < 2) send_item(REQ_FINISH, 8'($urandom), 1'b0, '0);
    else if (k < 4) begin
      send_item(REQ_DATA, 8'($urandom), 1'b0, '0);
      send_item(2'($urandom_range(0, 1)), 8'($urandom), 1'b0, '0);
    end
  endtask

  initial begin
    digest_out_t err_res;
    int len;
    err_res = '{word: '0, idx: '0, status: 1'b1, last: 1'b1};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    fail_count = 0;
    items_sent = 0;
    words_seen = 0;
    idle_cycles = 0;
    stim_done = 0;
    restart_msg();
    foreach (blk_buf[i]) blk_buf[i] = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message straight after reset, then a repeat
    add_row(REQ_FINISH, 8'h00, 1'b1,
            '{word: 32'he3b0c442, idx: 3'd0, status: 1'b0, last: 1'b0});
    add_row(REQ_FINISH, 8'hff, 1'b1,
            '{word: 32'he3b0c442, idx: 3'd0, status: 1'b0, last: 1'b0});
    // data after completion, data and finish while in error
    add_row(REQ_DATA, 8'hff, 1'b1, err_res);
    add_row(REQ_DATA, 8'h00, 1'b1, err_res);
    add_row(REQ_FINISH, 8'h00, 1'b1, err_res);
    add_row(REQ_UNUSED, 8'haa);
    add_row(REQ_RESTART, 8'h55);
    // "abc"
    add_row(REQ_DATA, 8'h61);
    add_row(REQ_DATA, 8'h62);
    add_row(REQ_DATA, 8'h63);
    add_row(REQ_UNUSED, 8'h00);
    add_row(REQ_FINISH, 8'h00, 1'b1,
            '{word: 32'hba7816bf, idx: 3'd0, status: 1'b0, last: 1'b0});
    add_row(REQ_RESTART, 8'h00);
    add_row(REQ_DATA, 8'h00);
    add_row(REQ_DATA, 8'hff);
    add_row(REQ_FINISH, 8'h00);
    add_row(REQ_RESTART, 8'hff);
    foreach (dir_rows[i])
      send_item(dir_rows[i].req, dir_rows[i].data, dir_rows[i].has_exp, dir_rows[i].exp);

    // padding edges: marker forcing a second block, and a full data block
    send_message(56, 0);
    send_message(64, 0);
    while (items_sent < 210) begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(50, 70);
      send_message(len, 1);
    end
    s_tvalid <= 1'b0;
    stim_done = 1;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d request items, checked %0d result items", items_sent, words_seen);
    $display("covered padding edges, repeated finishes, error states and noise codes");
    if (fail_count == 0 && digest_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
